// ===== hdl/c3s_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Package for the 3x3 convolution stream core
// Shared constants, filter weights and control types of the core.
// ----------------------------------------------------------------------------
package c3s_pkg;

  localparam int C3S_WIDTH_REG_W  = 11;
  localparam int C3S_ROW_W        = 16;
  localparam int C3S_CFG_DATA_W   = 16;
  localparam int C3S_CFG_IDX_W    = 1;
  localparam int C3S_WEIGHT_W     = 15;
  localparam int C3S_ROUND_SHIFT  = 14;
  localparam int C3S_ROUND_HALF   = 1 << (C3S_ROUND_SHIFT - 1);

  localparam logic [C3S_CFG_IDX_W-1:0] C3S_REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [C3S_CFG_IDX_W-1:0] C3S_REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [C3S_WIDTH_REG_W-1:0] C3S_WIDTH_RESET  = 11'd1024;
  localparam logic [C3S_ROW_W-1:0]       C3S_HEIGHT_RESET = 16'd1024;

  // Q1.14 weights indexed by row offset, then column offset.
  localparam logic signed [C3S_WEIGHT_W-1:0] C3S_WEIGHT [3][3] = '{
    '{ 15'sd3277,   15'sd8192, -15'sd13107},
    '{-15'sd4915,   15'sd9830, -15'sd14746},
    '{ 15'sd6554,  15'sd11469,   15'sd1638}
  };

  typedef struct packed {
    logic valid;
    logic last;
  } c3s_ctrl_t;

endpackage

// ===== hdl/conv3x3_stencil_stream_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 convolution stream core
// Filters a raster pixel stream with a fixed 3x3 kernel.
// ----------------------------------------------------------------------------
// Samples enter on the input channel in raster order, one transaction each,
// with frame_start_i marking row 0, column 0 of a frame. Every sample that
// completes a 3x3 neighborhood (row and column at least 2) yields one output
// transaction carrying the filtered center pixel; border pixels yield none.
// last_in_frame_o marks the result of the final sample of the frame.
// The configuration channel is always ready and sets image width and height;
// write it only while the core is idle.
// The core takes one sample per clock cycle while the receiver does not stall
// a waiting result. Once a sample is accepted, the line store read at
// acceptance is followed by window update, products, partial sums, then
// rounding and saturation into the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// the input channel is stalled in the same cycle.
// Reset clears the counters, the window and all valid flags, and sets width
// and height to 1024. The line stores are not cleared.
// ----------------------------------------------------------------------------
module conv3x3_stencil_stream_core
  import c3s_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] out_value_o,
  output logic                          last_in_frame_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [C3S_CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [C3S_CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = COL_W + 1;

  logic [C3S_WIDTH_REG_W-1:0] width_q;
  logic [C3S_ROW_W-1:0]       height_q;
  logic [WID_W-1:0]           width_eff;
  logic [C3S_ROW_W-1:0]       height_eff;

  logic [COL_W-1:0]     col_q, col_d, col_cur;
  logic [C3S_ROW_W-1:0] row_q, row_d, row_cur;
  logic                 row_end, frame_end, produce;
  logic                 enable, in_accept;

  logic                          s1_valid_q;
  logic [COL_W-1:0]              s1_col_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  c3s_ctrl_t                     s1_ctrl_q;

  logic                          fwd_q;
  logic signed [SAMPLE_BITS-1:0] fwd_up_q, fwd_mid_q;
  logic                          fwd_hit;

  logic [SAMPLE_BITS-1:0]        up_rd, mid_rd;
  logic signed [SAMPLE_BITS-1:0] up_s1, mid_s1;
  logic                          s1_write;

  logic signed [SAMPLE_BITS-1:0] win_q [3][3];
  c3s_ctrl_t                     win_ctrl_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= C3S_WIDTH_RESET;
      height_q <= C3S_HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        C3S_REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[C3S_WIDTH_REG_W-1:0];
        C3S_REG_IMAGE_HEIGHT: height_q <= cfg_data_i[C3S_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < C3S_WIDTH_REG_W'(3)) begin
      width_eff = WID_W'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else begin
      width_eff = WID_W'(width_q);
    end
    height_eff = (height_q < C3S_ROW_W'(3)) ? C3S_ROW_W'(3) : height_q;
  end

  // The pipeline advances unless a finished result is held by the receiver.
  assign enable     = !(out_valid_o && out_stall_i);
  assign in_stall_o = !enable;
  assign in_accept  = in_valid_i && enable;

  // Position of the incoming sample and the counters that follow it.
  always_comb begin
    col_cur   = frame_start_i ? '0 : col_q;
    row_cur   = frame_start_i ? '0 : row_q;
    row_end   = ({1'b0, col_cur} + WID_W'(1)) >= width_eff;
    frame_end = row_end &&
                (({1'b0, row_cur} + (C3S_ROW_W+1)'(1)) >= {1'b0, height_eff});
    produce   = (row_cur >= C3S_ROW_W'(2)) && (col_cur >= COL_W'(2));
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_cur + C3S_ROW_W'(1);
    end else begin
      col_d = col_cur + COL_W'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores: read at acceptance, written back from the registered s1 stage.
  assign s1_write = enable && s1_valid_q;

  c3s_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_col_q),
    .wdata_i (mid_s1),
    .re_i    (enable),
    .raddr_i (col_cur),
    .rdata_o (up_rd)
  );

  c3s_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_col_q),
    .wdata_i (s1_sample_q),
    .re_i    (enable),
    .raddr_i (col_cur),
    .rdata_o (mid_rd)
  );

  // A read of the column that is being written this cycle takes the new data.
  assign fwd_hit = in_accept && s1_valid_q && (col_cur == s1_col_q);
  assign up_s1   = fwd_q ? fwd_up_q  : $signed(up_rd);
  assign mid_s1  = fwd_q ? fwd_mid_q : $signed(mid_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
      fwd_q      <= 1'b0;
      win_ctrl_q <= '0;
    end else if (enable) begin
      s1_valid_q       <= in_accept;
      s1_ctrl_q.valid  <= in_accept && produce;
      s1_ctrl_q.last   <= frame_end;
      fwd_q            <= fwd_hit;
      win_ctrl_q.valid <= s1_valid_q && s1_ctrl_q.valid;
      win_ctrl_q.last  <= s1_ctrl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enable) begin
      s1_col_q    <= col_cur;
      s1_sample_q <= sample_i;
      fwd_up_q    <= mid_s1;
      fwd_mid_q   <= s1_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_write) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= up_s1;
      win_q[1][2] <= mid_s1;
      win_q[2][2] <= s1_sample_q;
    end
  end

  c3s_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (enable),
    .win_i   (win_q),
    .ctrl_i  (win_ctrl_q),
    .valid_o (out_valid_o),
    .last_o  (last_in_frame_o),
    .value_o (out_value_o)
  );

endmodule

// ===== hdl/c3s_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module c3s_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/c3s_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted sum pipeline
// Multiplies a 3x3 window by the fixed weights, sums, rounds and saturates.
// ----------------------------------------------------------------------------
module c3s_mac
  import c3s_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] win_i [3][3],
  input  c3s_ctrl_t                     ctrl_i,
  output logic                          valid_o,
  output logic                          last_o,
  output logic signed [SAMPLE_BITS-1:0] value_o
);

  localparam int PROD_W = SAMPLE_BITS + C3S_WEIGHT_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 4;
  localparam int Q_W    = ACC_W - C3S_ROUND_SHIFT;

  localparam logic signed [Q_W-1:0] Q_MAX =
    {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN =
    {{(Q_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0]      prod_q [3][3];
  logic signed [PSUM_W-1:0]      psum_q [3];
  c3s_ctrl_t                     prod_ctrl_q;
  c3s_ctrl_t                     psum_ctrl_q;
  c3s_ctrl_t                     out_ctrl_q;
  logic signed [SAMPLE_BITS-1:0] value_q;
  logic signed [SAMPLE_BITS-1:0] value_d;
  logic signed [ACC_W-1:0]       acc;
  logic signed [Q_W-1:0]         rounded;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= PROD_W'(win_i[i][j]) * PROD_W'(C3S_WEIGHT[i][j]);
        end
        psum_q[i] <= PSUM_W'(prod_q[i][0]) + PSUM_W'(prod_q[i][1])
                   + PSUM_W'(prod_q[i][2]);
      end
      value_q <= value_d;
    end
  end

  always_comb begin
    acc = ACC_W'(psum_q[0]) + ACC_W'(psum_q[1]) + ACC_W'(psum_q[2])
        + ACC_W'(C3S_ROUND_HALF);
    rounded = Q_W'(acc >>> C3S_ROUND_SHIFT);
    if (rounded > Q_MAX) begin
      value_d = Q_MAX[SAMPLE_BITS-1:0];
    end else if (rounded < Q_MIN) begin
      value_d = Q_MIN[SAMPLE_BITS-1:0];
    end else begin
      value_d = rounded[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ctrl_q <= '0;
      psum_ctrl_q <= '0;
      out_ctrl_q  <= '0;
    end else if (en_i) begin
      prod_ctrl_q <= ctrl_i;
      psum_ctrl_q <= prod_ctrl_q;
      out_ctrl_q  <= psum_ctrl_q;
    end
  end

  assign valid_o = out_ctrl_q.valid;
  assign last_o  = out_ctrl_q.last;
  assign value_o = value_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the 3x3 convolution stream core
// Drives raster pixel frames through the core and checks every filtered
// pixel. A directed table covers saturation, short registers and frame start
// handling. Random frames of many sizes follow, some of them resized in the
// middle of a frame. Both channels are throttled at random. An in-bench
// model of the line stores and the window predicts each result not given by the table.
// ----------------------------------------------------------------------------
module testbench;
  import c3s_pkg::*;

  localparam int MAX_W = 1024;
  localparam int ROUND_HALF = 8192;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_SAMPLES = 470;
  localparam logic signed [15:0] SAT_HI = 16'sh7FFF;
  localparam logic signed [15:0] SAT_LO = 16'sh8000;

  localparam int KERNEL [3][3] = '{
    '{ 3277,  8192, -13107},
    '{-4915,  9830, -14746},
    '{ 6554, 11469,   1638}
  };

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start;
    logic               typed;
    logic signed [15:0] value;
    logic               last;
  } probe_t;

  localparam probe_t DIRECTED_ROWS [20] = '{
    '{SAT_HI, 1'b1, 1'b0, 16'sh0, 1'b0},
    '{SAT_HI, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_HI, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_HI, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_HI, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_HI, 1'b0, 1'b1, SAT_HI, 1'b1},
    '{16'sh0000, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{16'shFFFF, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b1, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_HI, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_HI, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_HI, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b0, 1'b0, 16'sh0, 1'b0},
    '{SAT_LO, 1'b0, 1'b1, SAT_LO, 1'b1}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [15:0]         sample_i = '0;
  logic                       frame_start_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [15:0]         out_value_o;
  logic                       last_in_frame_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [C3S_CFG_IDX_W-1:0]   cfg_index_i = C3S_REG_IMAGE_WIDTH;
  logic [C3S_CFG_DATA_W-1:0]  cfg_data_i = '0;

  bit signed [15:0] upper_line [MAX_W];
  bit signed [15:0] middle_line [MAX_W];
  bit signed [15:0] window [3][3];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;
  logic [10:0]      width_reg = C3S_WIDTH_RESET;
  logic [15:0]      height_reg = C3S_HEIGHT_RESET;

  pixel_t pending_pixels [$];
  int     idle_pct = 16;
  int     stall_pct = 16;
  int     error_count = 0;
  int     pixels_checked = 0;
  int     samples_sent = 0;
  int     size_settings = 0;
  int     cycle_count = 0;

  conv3x3_stencil_stream_core DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned columns_of(input logic [10:0] w);
    if (w < 3) return 3;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic int unsigned rows_of(input logic [15:0] h);
    return (h < 3) ? 3 : h;
  endfunction

  function automatic bit filter_pixel(input logic signed [15:0] s, input logic fs,
                                      output pixel_t px);
    int unsigned w, h, c, r;
    longint      acc, q;
    bit          row_end, frame_end, produced;
    w = columns_of(width_reg);
    h = rows_of(height_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    for (int i = 0; i < 3; i++) begin
      window[i][0] = window[i][1];
      window[i][1] = window[i][2];
    end
    window[0][2] = upper_line[c];
    window[1][2] = middle_line[c];
    window[2][2] = s;
    upper_line[c] = middle_line[c];
    middle_line[c] = s;
    row_end = (c + 1 >= w);
    frame_end = row_end && (r + 1 >= h);
    produced = (r >= 2) && (c >= 2);
    px = '0;
    if (produced) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          acc += longint'(KERNEL[i][k]) * longint'(window[i][k]);
        end
      end
      q = (acc + ROUND_HALF) >>> 14;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      px.value = q[15:0];
      px.last = frame_end;
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      col_pos = c + 1;
    end
    return produced;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return SAT_HI;
      1: return SAT_LO;
      2, 3, 4: return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [15:0] s, input logic fs, input bit typed,
                             input logic signed [15:0] typed_value, input logic typed_last);
    pixel_t px;
    bit     produced;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    produced = filter_pixel(s, fs, px);
    if (typed) begin
      px.value = typed_value;
      px.last = typed_last;
    end
    if (produced || typed) pending_pixels.push_back(px);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_size(input logic [15:0] w_word, input logic [15:0] h_word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= C3S_REG_IMAGE_WIDTH;
    cfg_data_i <= w_word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    width_reg = w_word[10:0];
    cfg_index_i <= C3S_REG_IMAGE_HEIGHT;
    cfg_data_i <= h_word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    height_reg = h_word;
    cfg_valid_i <= 1'b0;
    size_settings++;
  endtask

  task automatic run_frames(input logic [15:0] w_word, input logic [15:0] h_word,
                            input bit open_with_start, input int count);
    drain();
    program_size(w_word, h_word);
    for (int n = 0; n < count; n++) begin
      send_sample(pick_sample(), (n == 0 && open_with_start) || ($urandom_range(99) < 2),
                  1'b0, 16'sh0, 1'b0);
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    pixel_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected filtered pixel: out_value %0d, last_in_frame %0b",
               out_value_o, last_in_frame_o);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_value_o !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value_o);
          error_count++;
        end
        if (last_in_frame_o !== want.last) begin
          $error("last_in_frame: expected %0b, got %0b", want.last, last_in_frame_o);
          error_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int          random_sent;
    int unsigned w, h, cap;
    bit          resize_open;
    random_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_size(16'd2, 16'd0);
    for (int i = 0; i < 20; i++) begin
      send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last);
    end

    idle_pct = 0;
    stall_pct = 0;
    run_frames(16'd12, 16'd8, 1'b1, 2 * 12 * 8);
    idle_pct = 16;
    stall_pct = 16;
    run_frames(16'd3, 16'hFFFF, 1'b1, 15);

    while (random_sent < RANDOM_SAMPLES) begin
      idle_pct = ($urandom_range(4) == 0) ? 0 : 16;
      stall_pct = idle_pct;
      resize_open = ($urandom_range(3) == 0);
      if (resize_open) begin
        cap = columns_of(width_reg);
        w = $urandom_range(3, (cap < 16) ? cap : 16);
      end else if ($urandom_range(7) == 0) begin
        w = $urandom_range(0, 2);
      end else begin
        w = $urandom_range(3, 16);
      end
      h = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      cap = columns_of(11'(w)) * rows_of(16'(h)) * $urandom_range(1, 2)
            + $urandom_range(0, 2 * columns_of(11'(w)));
      run_frames({5'($urandom), 11'(w)}, 16'(h), !resize_open, cap);
      random_sent += cap;
    end

    drain();
    $display("Summary: %0d samples over %0d size settings, %0d filtered pixels compared.",
             samples_sent, size_settings, pixels_checked);
    $display("Summary: widths 3 to 16 and clamped short widths, heights 3 to 65535, %s",
             "resizes and restarts mid-frame.");
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/c3s_pkg.sv
hdl/c3s_ram.sv
hdl/c3s_mac.sv
hdl/conv3x3_stencil_stream_core.sv
sim/testbench.sv
